FILE: rtl/bafl_pkg.sv
package bafl_pkg;

  // fixed-point formats
  localparam int FRAC_BITS = 16;
  localparam int GAIN_W    = 17;
  localparam int GAIN_ONE  = 65536;
  localparam int ROT_SHIFT = 14;
  localparam int DT_FRAC   = 20;
  localparam int DT_SHIFT  = 21;
  localparam longint GRAVITY_Q = (981 * (64'sd1 <<< FRAC_BITS) + 50) / 100;

  // shift-add multiplier sizing
  localparam int MUL_AW = 33;
  localparam int MUL_BW = 22;
  localparam int MUL_CW = $clog2(MUL_BW);
  localparam int ACC_W  = 57;

  // restoring divider sizing
  localparam int DIV_NW = 54;
  localparam int DIV_DW = 21;
  localparam int DIV_CW = $clog2(DIV_NW);

  typedef struct packed {
    logic                     start;
    logic signed [MUL_AW-1:0] a;
    logic signed [MUL_BW-1:0] b;
    logic signed [ACC_W-1:0]  init;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sd2147483647);
    lo = ACC_W'(-64'sd2147483648);
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // gains above one act as one
  function automatic logic [GAIN_W-1:0] gain_clamp(input logic [GAIN_W-1:0] g);
    if (g > GAIN_W'(GAIN_ONE)) return GAIN_W'(GAIN_ONE);
    else return g;
  endfunction

  // negate with saturation of the most negative value
  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    if (v == 32'sh80000000) return 32'sh7fffffff;
    else return -v;
  endfunction

endpackage

FILE: rtl/baro_accel_altitude_filter.sv
// query items and any item before the first baro sample skip the arithmetic units
// accel items run seven serial multiplies, 22 multiplier bits each
// baro items run three multiplies and one 54-bit division
// one item at a time: a new item is taken only once the last has left the
// sequencer; the next transfer is taken while the result waits at the output
// reset: synchronous active-low rst_n clears the estimate, sets warm-up, loads default gains
module baro_accel_altitude_filter import bafl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [24:0] in_accel_x,
  input  logic signed [24:0] in_accel_y,
  input  logic signed [24:0] in_accel_z,
  input  logic signed [15:0] in_rot_xz,
  input  logic signed [15:0] in_rot_yz,
  input  logic signed [15:0] in_rot_zz,
  input  logic signed [30:0] in_baro_altitude,
  input  logic [20:0]        in_interval,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_down_position,
  output logic signed [31:0] out_down_velocity,
  output logic               out_valid_res,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_BARO  = 2'd1;

  localparam logic [1:0] CFG_LPF   = 2'd0;
  localparam logic [1:0] CFG_DRIFT = 2'd1;
  localparam logic [1:0] CFG_BARO  = 2'd2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  localparam logic [3:0] OP_P1   = 4'd0;
  localparam logic [3:0] OP_P2   = 4'd1;
  localparam logic [3:0] OP_P3   = 4'd2;
  localparam logic [3:0] OP_LPF  = 4'd3;
  localparam logic [3:0] OP_OFF  = 4'd4;
  localparam logic [3:0] OP_SPD  = 4'd5;
  localparam logic [3:0] OP_ALT  = 4'd6;
  localparam logic [3:0] OP_BALT = 4'd7;
  localparam logic [3:0] OP_B2   = 4'd8;
  localparam logic [3:0] OP_DIV  = 4'd9;
  localparam logic [3:0] OP_BSPD = 4'd10;

  localparam logic signed [ACC_W-1:0] RND_ROT = ACC_W'(64'sd1 <<< (ROT_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] RND_Q   = ACC_W'(64'sd1 <<< 15);
  localparam logic signed [ACC_W-1:0] RND_DT  = ACC_W'(64'sd1 <<< (DT_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] GRAV    = ACC_W'(GRAVITY_Q);
  localparam logic [DIV_NW-1:0]       Q_LIMIT = DIV_NW'(64'd2147483648);

  // configuration
  logic [GAIN_W-1:0] lpg_r, drg_r, bg_r;
  logic [GAIN_W-1:0] lpg_c, drg_c, bg_c;

  // filter state
  logic signed [31:0] alt_r, spd_r, off_r, filt_r, pca_r, pbaro_r;
  logic               warm_r;

  // sequencer
  logic [1:0] st_r;
  logic [3:0] op_r;

  // latched item and intermediates
  logic signed [24:0] ax_r, ay_r, az_r;
  logic signed [15:0] rx_r, ry_r, rz_r;
  logic signed [30:0] baro_r;
  logic [20:0]        dt_r;
  logic signed [31:0] cur_r, corr_r, oldspd_r, rate_r;
  logic signed [32:0] diff_r;
  logic [GAIN_W-1:0]  b2_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] out_pos_r, out_vel_r;
  logic               out_res_r;

  // shared units
  mul_req_t                mul_req;
  div_req_t                div_req;
  logic                    mul_done, div_done, unit_done;
  logic signed [ACC_W-1:0] mul_acc;
  logic [DIV_NW-1:0]       div_quot;

  logic signed [ACC_W-1:0] acc_q16, acc_q21, acc_rot;
  logic signed [31:0]      filt_upd, off_upd;
  logic [32:0]             diff_abs;
  logic [31:0]             q_sat;
  logic signed [32:0]      rate_wide;
  logic                    in_xfer, out_load;

  assign lpg_c = gain_clamp(lpg_r);
  assign drg_c = gain_clamp(drg_r);
  assign bg_c  = gain_clamp(bg_r);

  assign in_ready = (st_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (st_r == ST_FIN) && (!out_valid_r || out_ready);

  // multiplier operand selection
  always_comb begin
    mul_req       = '0;
    mul_req.start = (st_r == ST_ISSUE) && (op_r != OP_DIV);
    unique case (op_r)
      OP_P1: begin
        mul_req.a    = MUL_AW'(ax_r);
        mul_req.b    = MUL_BW'(rx_r);
        mul_req.init = RND_ROT;
      end
      OP_P2: begin
        mul_req.a    = MUL_AW'(ay_r);
        mul_req.b    = MUL_BW'(ry_r);
        mul_req.init = mul_acc;
      end
      OP_P3: begin
        mul_req.a    = MUL_AW'(az_r);
        mul_req.b    = MUL_BW'(rz_r);
        mul_req.init = mul_acc;
      end
      OP_LPF: begin
        mul_req.a    = MUL_AW'(cur_r) - MUL_AW'(filt_r);
        mul_req.b    = MUL_BW'({1'b0, lpg_c});
        mul_req.init = RND_Q;
      end
      OP_OFF: begin
        mul_req.a    = MUL_AW'(filt_r) - MUL_AW'(off_r);
        mul_req.b    = MUL_BW'({1'b0, drg_c});
        mul_req.init = RND_Q;
      end
      OP_SPD: begin
        mul_req.a    = MUL_AW'(pca_r) + MUL_AW'(corr_r);
        mul_req.b    = MUL_BW'({1'b0, dt_r});
        mul_req.init = RND_DT;
      end
      OP_ALT: begin
        mul_req.a    = MUL_AW'(oldspd_r) + MUL_AW'(spd_r);
        mul_req.b    = MUL_BW'({1'b0, dt_r});
        mul_req.init = RND_DT;
      end
      OP_BALT: begin
        mul_req.a    = MUL_AW'(baro_r) - MUL_AW'(alt_r);
        mul_req.b    = MUL_BW'({1'b0, bg_c});
        mul_req.init = RND_Q;
      end
      OP_B2: begin
        mul_req.a    = MUL_AW'({1'b0, bg_c});
        mul_req.b    = MUL_BW'({1'b0, bg_c});
        mul_req.init = RND_Q;
      end
      OP_BSPD: begin
        mul_req.a    = MUL_AW'(rate_r) - MUL_AW'(spd_r);
        mul_req.b    = MUL_BW'({1'b0, b2_r});
        mul_req.init = RND_Q;
      end
      default: begin
        mul_req.a    = '0;
        mul_req.b    = '0;
        mul_req.init = '0;
      end
    endcase
  end

  // baro rate division: rounded magnitude, sign applied after
  assign diff_abs      = diff_r[32] ? 33'(-diff_r) : 33'(diff_r);
  assign div_req.start = (st_r == ST_ISSUE) && (op_r == OP_DIV);
  assign div_req.num   = (DIV_NW'(diff_abs) << DT_FRAC) + DIV_NW'(dt_r >> 1);
  assign div_req.den   = dt_r;

  bafl_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .done (mul_done),
    .acc  (mul_acc)
  );

  bafl_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  assign unit_done = (op_r == OP_DIV) ? div_done : mul_done;

  // rescaled products and updates
  assign acc_rot  = mul_acc >>> ROT_SHIFT;
  assign acc_q16  = mul_acc >>> 16;
  assign acc_q21  = mul_acc >>> DT_SHIFT;
  assign filt_upd = sat32(ACC_W'(filt_r) + acc_q16);
  assign off_upd  = sat32(ACC_W'(off_r) + acc_q16);

  assign q_sat     = (div_quot > Q_LIMIT) ? 32'h80000000 : div_quot[31:0];
  assign rate_wide = diff_r[32] ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpg_r <= GAIN_W'(6554);
      drg_r <= GAIN_W'(66);
      bg_r  <= GAIN_W'(3277);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LPF:   lpg_r <= cfg_data;
        CFG_DRIFT: drg_r <= cfg_data;
        CFG_BARO:  bg_r  <= cfg_data;
        default:   ;
      endcase
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      op_r        <= OP_P1;
      warm_r      <= 1'b1;
      alt_r       <= '0;
      spd_r       <= '0;
      off_r       <= '0;
      filt_r      <= '0;
      pca_r       <= '0;
      pbaro_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result valid: set on load, cleared on transfer
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (warm_r) begin
              if (in_kind == KIND_BARO) warm_r <= 1'b0;
              st_r <= ST_FIN;
            end else if (in_kind == KIND_ACCEL) begin
              op_r <= OP_P1;
              st_r <= ST_ISSUE;
            end else if (in_kind == KIND_BARO) begin
              op_r <= OP_BALT;
              st_r <= ST_ISSUE;
            end else begin
              st_r <= ST_FIN;
            end
          end
        end
        ST_ISSUE: st_r <= ST_WAIT;
        ST_WAIT: begin
          if (unit_done) begin
            st_r <= ST_ISSUE;
            unique case (op_r)
              OP_P1:  op_r <= OP_P2;
              OP_P2:  op_r <= OP_P3;
              OP_P3:  op_r <= OP_LPF;
              OP_LPF: begin
                filt_r <= filt_upd;
                op_r   <= OP_OFF;
              end
              OP_OFF: begin
                off_r <= off_upd;
                op_r  <= OP_SPD;
              end
              OP_SPD: begin
                spd_r <= sat32(ACC_W'(spd_r) + acc_q21);
                pca_r <= corr_r;
                op_r  <= OP_ALT;
              end
              OP_ALT: begin
                alt_r <= sat32(ACC_W'(alt_r) + acc_q21);
                st_r  <= ST_FIN;
              end
              OP_BALT: begin
                alt_r <= sat32(ACC_W'(alt_r) + acc_q16);
                op_r  <= OP_B2;
              end
              OP_B2:  op_r <= OP_DIV;
              OP_DIV: op_r <= OP_BSPD;
              OP_BSPD: begin
                spd_r   <= sat32(ACC_W'(spd_r) + acc_q16);
                pbaro_r <= 32'(baro_r);
                st_r    <= ST_FIN;
              end
              default: st_r <= ST_FIN;
            endcase
          end
        end
        ST_FIN: begin
          if (out_load) st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // item latch, intermediates and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ax_r   <= in_accel_x;
      ay_r   <= in_accel_y;
      az_r   <= in_accel_z;
      rx_r   <= in_rot_xz;
      ry_r   <= in_rot_yz;
      rz_r   <= in_rot_zz;
      baro_r <= in_baro_altitude;
      dt_r   <= (in_interval == '0) ? 21'd1 : in_interval;
    end
    if ((st_r == ST_WAIT) && unit_done) begin
      unique case (op_r)
        OP_P3:   cur_r <= sat32(-(acc_rot + GRAV));
        OP_OFF:  corr_r <= sat32(ACC_W'(filt_r) - ACC_W'(off_upd));
        OP_SPD:  oldspd_r <= spd_r;
        OP_BALT: diff_r <= 33'(baro_r) - 33'(pbaro_r);
        OP_B2:   b2_r <= acc_q16[GAIN_W-1:0];
        OP_DIV:  rate_r <= sat32(ACC_W'(rate_wide));
        default: ;
      endcase
    end
    if (out_load) begin
      out_pos_r <= neg_sat(alt_r);
      out_vel_r <= neg_sat(spd_r);
      out_res_r <= !warm_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_down_position = out_pos_r;
  assign out_down_velocity = out_vel_r;
  assign out_valid_res     = out_res_r;

  // units report completion only to a waiting sequencer
  a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (st_r == ST_WAIT) && (op_r != OP_DIV))
    else $error("multiplier done outside wait");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == ST_WAIT) && (op_r == OP_DIV))
    else $error("divider done outside wait");

  // warm-up ends only on a baro transfer
  a_warm_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(warm_r) |-> $past(in_xfer && (in_kind == KIND_BARO)))
    else $error("warm-up cleared without baro transfer");

  // state only moves while an item is in work
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) && !in_valid |=> $stable(alt_r) && $stable(spd_r))
    else $error("estimate changed while idle");

endmodule

FILE: rtl/bafl_mul.sv
module bafl_mul import bafl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mul_req_t                req,
  output logic                    done,
  output logic signed [ACC_W-1:0] acc
);

  logic                    busy_r;
  logic                    done_r;
  logic [MUL_CW-1:0]       cnt_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] mcand_r;
  logic [MUL_BW-1:0]       mplier_r;
  logic                    last;

  assign last = (cnt_r == MUL_CW'(MUL_BW - 1));

  // one multiplier bit per cycle, the sign bit weighs negative
  always_comb begin
    acc_nxt = acc_r;
    if (mplier_r[0]) begin
      if (last) acc_nxt = acc_r - mcand_r;
      else acc_nxt = acc_r + mcand_r;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand shifters and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r    <= req.init;
      mcand_r  <= ACC_W'(req.a);
      mplier_r <= req.b;
    end else if (busy_r) begin
      acc_r    <= acc_nxt;
      mcand_r  <= mcand_r <<< 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

FILE: rtl/bafl_div.sv
module bafl_div import bafl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  output logic              done,
  output logic [DIV_NW-1:0] quot
);

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW:0]   trial;
  logic              ge;
  logic [DIV_DW-1:0] rem_nxt;

  // one quotient bit per cycle
  assign trial   = {rem_r, num_r[DIV_NW-1]};
  assign ge      = (trial >= {1'b0, den_r});
  assign rem_nxt = ge ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out, quotient shifts in
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

FILE: test/baro_accel_altitude_filter_tb.sv
`timescale 1ns / 100ps

module baro_accel_altitude_filter_tb;
  import bafl_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_BARO  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_SPARE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_ACCEL_LP    = 2'd0,
    REG_ACCEL_DRIFT = 2'd1,
    REG_BARO_GAIN   = 2'd2
  } reg_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [24:0] ax;
    logic signed [24:0] ay;
    logic signed [24:0] az;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] rz;
    logic signed [30:0] baro;
    logic [20:0]        interval;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               vres;
  } estimate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = '0;
  logic signed [24:0] in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  logic signed [15:0] in_rot_xz = '0, in_rot_yz = '0, in_rot_zz = '0;
  logic signed [30:0] in_baro_altitude = '0;
  logic [20:0] in_interval = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_down_position, out_down_velocity;
  logic out_valid_res;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  baro_accel_altitude_filter u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [16:0] g_lp, g_drift, g_baro;
  longint est_alt, est_speed, est_off, est_filt, est_prev_corr, est_prev_baro;
  bit est_warm;

  sample_t   pending_samples[$];
  estimate_t expected_estimates[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round half up: add half then arithmetic shift (floor)
  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_gain(logic [16:0] g);
    return (g > 17'd65536) ? 64'sd65536 : longint'(g);
  endfunction

  function automatic longint lowpass(longint g, longint old, longint x);
    return sat_q(rnd_shift((64'sd65536 - g) * old + g * x, 16));
  endfunction

  function automatic logic signed [31:0] negate_q(longint v);
    return 32'(sat_q(-v));
  endfunction

  task automatic fold_accel(sample_t s);
    longint proj, cur, corr, old_v, dt;
    dt = (s.interval == 0) ? 1 : longint'(s.interval);
    proj = rnd_shift(longint'(s.rx) * s.ax + longint'(s.ry) * s.ay +
                     longint'(s.rz) * s.az, ROT_SHIFT);
    cur = sat_q(-(proj + GRAVITY_Q));
    est_filt = lowpass(clamp_gain(g_lp), est_filt, cur);
    est_off = lowpass(clamp_gain(g_drift), est_off, est_filt);
    corr = sat_q(est_filt - est_off);
    old_v = est_speed;
    est_speed = sat_q(est_speed + rnd_shift((est_prev_corr + corr) * dt, DT_SHIFT));
    est_prev_corr = corr;
    est_alt = sat_q(est_alt + rnd_shift((old_v + est_speed) * dt, DT_SHIFT));
  endtask

  task automatic fold_baro(sample_t s);
    longint b, b2, diff, dt, rate;
    longint unsigned mag, q;
    dt = (s.interval == 0) ? 1 : longint'(s.interval);
    b = clamp_gain(g_baro);
    b2 = (b * b + 32768) >>> 16;
    diff = longint'(s.baro) - est_prev_baro;
    est_alt = lowpass(b, est_alt, longint'(s.baro));
    mag = longint'(diff < 0 ? -diff : diff) << 20;
    q = (mag + longint'(dt) / 2) / longint'(dt);
    if (q > 64'h80000000) q = 64'h80000000;
    rate = (diff < 0) ? -longint'(q) : longint'(q);
    est_speed = lowpass(b2, est_speed, sat_q(rate));
    est_prev_baro = longint'(s.baro);
  endtask

  task automatic predict_estimate(sample_t s);
    estimate_t e;
    if (est_warm) begin
      if (s.kind == KIND_BARO) est_warm = 0;
    end else if (s.kind == KIND_ACCEL) begin
      fold_accel(s);
    end else if (s.kind == KIND_BARO) begin
      fold_baro(s);
    end
    e.pos = negate_q(est_alt);
    e.vel = negate_q(est_speed);
    e.vres = !est_warm;
    expected_estimates.push_back(e);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_t s;
        s = pending_samples.pop_front();
        predict_estimate(s);
        in_valid <= 1'b1;
        in_kind <= s.kind;
        in_accel_x <= s.ax;
        in_accel_y <= s.ay;
        in_accel_z <= s.az;
        in_rot_xz <= s.rx;
        in_rot_yz <= s.ry;
        in_rot_zz <= s.rz;
        in_baro_altitude <= s.baro;
        in_interval <= s.interval;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_estimates.size() == 0) begin
          report_mismatch("unexpected transfer", 0, 0);
        end else begin
          estimate_t e;
          e = expected_estimates.pop_front();
          if (out_down_position !== e.pos)
            report_mismatch("down_position", out_down_position, e.pos);
          if (out_down_velocity !== e.vel)
            report_mismatch("down_velocity", out_down_velocity, e.vel);
          if (out_valid_res !== e.vres)
            report_mismatch("valid_res", out_valid_res, e.vres);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic sample_t rand_sample(logic [1:0] kind, bit wild);
    sample_t s;
    s.kind = kind;
    s.ax = wild ? 25'($urandom) : 25'($signed($urandom_range(20971520)) - 10485760);
    s.ay = wild ? 25'($urandom) : 25'($signed($urandom_range(20971520)) - 10485760);
    s.az = wild ? 25'($urandom) : 25'($signed($urandom_range(20971520)) - 10485760);
    s.rx = wild ? 16'($urandom) : 16'($signed($urandom_range(32768)) - 16384);
    s.ry = wild ? 16'($urandom) : 16'($signed($urandom_range(32768)) - 16384);
    s.rz = wild ? 16'($urandom) : 16'($signed($urandom_range(32768)) - 16384);
    s.baro = wild ? 31'($urandom) : 31'($signed($urandom_range(721296000)) - 65536000);
    case ($urandom_range(3))
      0: s.interval = 21'($urandom);
      1: s.interval = 21'($urandom_range(1, 64));
      default: s.interval = 21'($urandom_range(800, 1200));
    endcase
    return s;
  endfunction

  task automatic wait_drained();
    while (pending_samples.size() > 0 || expected_estimates.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(reg_e idx, logic [16:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ACCEL_LP:    g_lp = val;
      REG_ACCEL_DRIFT: g_drift = val;
      default:         g_baro = val;
    endcase
  endtask

  initial begin
    sample_t s;
    int r;
    g_lp = 17'd6554;
    g_drift = 17'd66;
    g_baro = 17'd3277;
    est_alt = 0; est_speed = 0; est_off = 0; est_filt = 0;
    est_prev_corr = 0; est_prev_baro = 0; est_warm = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: warm-up, extremes, zero interval, spare kind
    pending_samples.push_back(rand_sample(KIND_ACCEL, 0));
    pending_samples.push_back(rand_sample(KIND_QUERY, 0));
    s = rand_sample(KIND_BARO, 0); s.baro = 31'sd655360000;
    pending_samples.push_back(s);
    s = rand_sample(KIND_BARO, 0); s.baro = -31'sd65536000; s.interval = 0;
    pending_samples.push_back(s);
    s = rand_sample(KIND_BARO, 0); s.baro = 31'sd655360000; s.interval = 1;
    pending_samples.push_back(s);
    s = rand_sample(KIND_ACCEL, 0);
    s.ax = 25'sd10485760; s.ay = 25'sd10485760; s.az = 25'sd10485760;
    s.rx = 16'sd16384; s.ry = 16'sd16384; s.rz = 16'sd16384; s.interval = 21'd1048576;
    pending_samples.push_back(s);
    s.ax = -25'sd10485760; s.ay = -25'sd10485760; s.az = -25'sd10485760;
    s.interval = 0;
    pending_samples.push_back(s);
    s.rx = -16'sd16384; s.ry = -16'sd16384; s.rz = -16'sd16384;
    s.interval = 21'h1fffff;
    pending_samples.push_back(s);
    pending_samples.push_back(rand_sample(KIND_SPARE, 1));
    pending_samples.push_back(rand_sample(KIND_QUERY, 1));
    for (int i = 0; i < 6; i++) pending_samples.push_back(rand_sample(KIND_ACCEL, 1));
    wait_drained();

    // random phases across gain settings and idling profiles
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      case (ph)
        1: begin
          write_gain(REG_ACCEL_LP, 17'd65536);
          write_gain(REG_ACCEL_DRIFT, 17'd0);
          write_gain(REG_BARO_GAIN, 17'd65536);
        end
        2: begin
          write_gain(REG_ACCEL_LP, 17'd0);
          write_gain(REG_ACCEL_DRIFT, 17'd65536);
          write_gain(REG_BARO_GAIN, 17'd0);
        end
        3: begin
          write_gain(REG_ACCEL_LP, 17'h1ffff);
          write_gain(REG_ACCEL_DRIFT, 17'h1ffff);
          write_gain(REG_BARO_GAIN, 17'h1ffff);
        end
        5, 6, 7: begin
          write_gain(REG_ACCEL_LP, 17'($urandom));
          write_gain(REG_ACCEL_DRIFT, 17'($urandom));
          write_gain(REG_BARO_GAIN, 17'($urandom_range(65536)));
        end
        default: ;
      endcase
      for (int i = 0; i < 62; i++) begin
        r = $urandom_range(99);
        if (r < 60) pending_samples.push_back(rand_sample(KIND_ACCEL, r < 6));
        else if (r < 88) pending_samples.push_back(rand_sample(KIND_BARO, r < 64));
        else pending_samples.push_back(rand_sample(2'($urandom_range(2, 3)), 1));
      end
      wait_drained();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
